### rtl/core/base64_encoder_core_macros.svh
// assertion macros for the base64 encoder checker
// expects signals named clk and arst_n in the scope of use
`ifndef BASE64_ENCODER_CORE_MACROS_SVH
`define BASE64_ENCODER_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define B64_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("base64 encoder port check failed");

// condition implies consequence in the next cycle
`define B64_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base64 encoder port check failed");

`endif

### rtl/core/b64enc_pkg.sv
// shared types, constants and the sextet to ascii map of the base64 encoder
// no dependencies
`timescale 1ns / 1ps

package b64enc_pkg;

	localparam logic [6:0] PadChar   = 7'd61;  // '='
	localparam logic [6:0] PlusChar  = 7'd43;  // '+'
	localparam logic [6:0] SlashChar = 7'd47;  // '/'

	// one complete or final group waiting to be expanded into characters
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  nbytes;
		logic        last;
	} group_t;

	typedef struct packed {
		logic   valid;
		group_t grp;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// standard alphabet lookup
	function automatic logic [6:0] sextet_to_char(input logic [5:0] v);
		logic [6:0] v7;
		logic [6:0] r;
		v7 = {1'b0, v};
		if (v < 6'd26) begin
			r = v7 + 7'd65;        // A-Z
		end else if (v < 6'd52) begin
			r = v7 + 7'd71;        // a-z
		end else if (v < 6'd62) begin
			r = v7 - 7'd4;         // 0-9
		end else if (v == 6'd62) begin
			r = PlusChar;
		end else begin
			r = SlashChar;
		end
		return r;
	endfunction

endpackage

### rtl/core/b64enc_stream_if.sv
// valid/ready channel interfaces: raw byte words in, ascii character words out
// depends on nothing
`timescale 1ns / 1ps

interface b64enc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64enc_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       end_of_group;
	logic       end_of_stream;

	modport source(output valid, output out_char, output end_of_group,
		output end_of_stream, input ready);
	modport sink(input valid, input out_char, input end_of_group,
		input end_of_stream, output ready);
endinterface

### rtl/core/b64enc_front.sv
// front end: gathers raw bytes into groups of up to three and pushes them
// depends on b64enc_pkg and b64enc_byte_if
`timescale 1ns / 1ps

module b64enc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	b64enc_byte_if.sink             raw,
	input  b64enc_pkg::qstat_t      qstat,
	output b64enc_pkg::push_t       push
);

	logic [1:0]  cnt_q;
	logic [15:0] pend_q;
	logic        completes;
	logic        acc;

	// a word closes a group on the last flag or as third byte
	assign completes = raw.last_byte || (cnt_q >= 2'd2);
	assign raw.ready = !completes || !qstat.full;
	assign acc       = raw.valid && raw.ready;

	// build the group from waiting bytes and the incoming one
	always_comb begin
		push.valid = acc && completes;
		push.grp.last = raw.last_byte;
		case (cnt_q)
			2'd0: begin
				push.grp.bits   = {raw.data_byte, 16'h0000};
				push.grp.nbytes = 2'd1;
			end
			2'd1: begin
				push.grp.bits   = {pend_q[15:8], raw.data_byte, 8'h00};
				push.grp.nbytes = 2'd2;
			end
			default: begin
				push.grp.bits   = {pend_q, raw.data_byte};
				push.grp.nbytes = 2'd3;
			end
		endcase
	end

	// byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (acc) begin
			if (completes) begin
				cnt_q <= 2'd0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// waiting bytes
	always_ff @(posedge clk) begin
		if (acc && !completes) begin
			if (cnt_q == 2'd0) begin
				pend_q <= {raw.data_byte, 8'h00};
			end else begin
				pend_q[7:0] <= raw.data_byte;
			end
		end
	end

endmodule

### rtl/core/b64enc_queue.sv
// two entry group queue between front and back end
// depends on b64enc_pkg
`timescale 1ns / 1ps

module b64enc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  b64enc_pkg::push_t       push,
	input  logic                    pop,
	output b64enc_pkg::qstat_t      qstat,
	output b64enc_pkg::group_t      head
);

	b64enc_pkg::group_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign head        = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.grp;
		end
	end

endmodule

### rtl/core/b64enc_back.sv
// back end: expands one group into four characters through an output register
// depends on b64enc_pkg and b64enc_char_if
`timescale 1ns / 1ps

module b64enc_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  b64enc_pkg::qstat_t      qstat,
	input  b64enc_pkg::group_t      head,
	output logic                    pop,
	b64enc_char_if.source           enc
);

	b64enc_pkg::group_t grp_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       ov_q;
	logic [6:0] char_q;
	logic       eog_q;
	logic       eos_q;
	logic       adv;
	logic       emit;
	logic       done;
	logic [5:0] sextet;
	logic       pad;
	logic [6:0] char_d;

	assign adv  = !ov_q || enc.ready;
	assign emit = adv && busy_q;
	assign done = emit && (idx_q == 2'd3);
	assign pop  = !qstat.empty && (!busy_q || done);

	// pick the sextet and decide on padding
	always_comb begin
		case (idx_q)
			2'd0:    sextet = grp_q.bits[23:18];
			2'd1:    sextet = grp_q.bits[17:12];
			2'd2:    sextet = grp_q.bits[11:6];
			default: sextet = grp_q.bits[5:0];
		endcase
		pad = ((idx_q == 2'd2) && (grp_q.nbytes < 2'd2))
			|| ((idx_q == 2'd3) && (grp_q.nbytes < 2'd3));
		char_d = pad ? b64enc_pkg::PadChar : b64enc_pkg::sextet_to_char(sextet);
	end

	// group sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (adv) begin
				ov_q <= busy_q;
			end
		end
	end

	// group and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head;
		end
		if (emit) begin
			char_q <= char_d;
			eog_q  <= (idx_q == 2'd3);
			eos_q  <= (idx_q == 2'd3) && grp_q.last;
		end
	end

	assign enc.valid         = ov_q;
	assign enc.out_char      = char_q;
	assign enc.end_of_group  = eog_q;
	assign enc.end_of_stream = eos_q;

endmodule

### rtl/core/base64_encoder_core.sv
// Streaming base64 encoder, standard alphabet with '=' padding.
// Channel raw takes one byte word a cycle with a last-byte flag; a byte
// that closes a group waits for room in the queue. Channel enc gives one
// ascii character word a cycle while enc is ready and groups are waiting;
// end_of_group marks the fourth character of each group, end_of_stream the
// final character. Bytes that do not close a group are held and produce
// nothing yet. Each group goes from a queue entry to the group register
// and its four characters through the single output register, one a cycle
// while enc is ready; raw keeps taking bytes while the two entry group
// queue has room.
// When enc stalls, the output register holds its word, the back end waits,
// the queue fills and raw.ready drops only for bytes that close a group.
// Reset clears the byte count, the queue and the output valid; a partial
// group in flight at reset is dropped.
// depends on b64enc_pkg, b64enc_stream_if, front, queue and back modules
`timescale 1ns / 1ps

module base64_encoder_core (
	input  logic            clk,
	input  logic            arst_n,
	b64enc_byte_if.sink     raw,
	b64enc_char_if.source   enc
);

	b64enc_pkg::push_t  push;
	b64enc_pkg::qstat_t qstat;
	b64enc_pkg::group_t head;
	logic               pop;

	// byte gathering
	b64enc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.qstat  (qstat),
		.push   (push)
	);

	// decoupling queue
	b64enc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	// character generation
	b64enc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.enc    (enc)
	);

endmodule

### rtl/core/b64enc_checker.sv
// port level checks of the base64 encoder output channel, bound to the top
// depends on base64_encoder_core_macros.svh and b64enc_pkg
`timescale 1ns / 1ps
`include "base64_encoder_core_macros.svh"

module b64enc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic       out_eog,
	input logic       out_eos
);

	logic [8:0] out_word;
	logic       out_pad;

	// whole output word and pad detect
	assign out_word = {out_char, out_eog, out_eos};
	assign out_pad  = (out_char == b64enc_pkg::PadChar);

	// stalled word holds
	`B64_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_word))

	// stream end only on a group end
	`B64_ASSERT_SAME(a_eos_eog, out_valid && out_eos, out_eog)

	// a pad inside a group is followed by another pad right away
	`B64_ASSERT_NEXT(a_pad_run, out_valid && out_ready && !out_eog && out_pad, out_valid && out_pad)

endmodule

bind base64_encoder_core b64enc_checker u_b64enc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (enc.valid),
	.out_ready (enc.ready),
	.out_char  (enc.out_char),
	.out_eog   (enc.end_of_group),
	.out_eos   (enc.end_of_stream)
);
